@@ hw/rtl/fpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants and stage records for the binary32 adder pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int EXP_W  = 8;
  localparam int FRAC_W = 23;
  localparam int WORD_W = 1 + EXP_W + FRAC_W;
  localparam int MANT_W = FRAC_W + 1;
  localparam int PAD    = FRAC_W + 2;
  localparam int SUM_W  = 2 * PAD;
  localparam int GAP_W  = $clog2(PAD + 1);
  localparam int TOP_W  = $clog2(SUM_W);
  localparam int XE_W   = EXP_W + 2;

  localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};
  localparam logic [WORD_W-1:0] NAN_WORD =
    {1'b0, EXP_MAX, 2'b01, {(FRAC_W - 2){1'b0}}};

  // operands after unpack and swap
  typedef struct packed {
    logic              special;
    logic [WORD_W-1:0] special_word;
    logic [EXP_W-1:0]  emax;
    logic [GAP_W-1:0]  gap;
    logic [MANT_W-1:0] mmax;
    logic [MANT_W-1:0] mmin;
    logic              smax;
    logic              smin;
  } align_t;

  // exact sum
  typedef struct packed {
    logic              special;
    logic [WORD_W-1:0] special_word;
    logic              zero;
    logic              sign;
    logic [EXP_W-1:0]  emax;
    logic [SUM_W-1:0]  sum;
  } sum_t;

  // normalized sum ready for rounding
  typedef struct packed {
    logic                   special;
    logic [WORD_W-1:0]      special_word;
    logic                   zero;
    logic                   sign;
    logic signed [XE_W-1:0] expo;
    logic [SUM_W-1:0]       sig;
  } norm_t;

endpackage

@@ hw/rtl/fpa_align.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_align
// Unpack and order the operands, then align the smaller one and add.
// Two register stages.
// ----------------------------------------------------------------------------
module fpa_align import fpa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] a_bits,
  input  logic [WORD_W-1:0] b_bits,
  output sum_t              sum_q
);

  align_t al, al_next;
  sum_t   sum_next;

  logic             sa, sb;
  logic [EXP_W-1:0] ea, eb, ediff;
  logic [FRAC_W-1:0] fa, fb;
  logic [MANT_W-1:0] ma, mb;
  logic              nan;

  always_comb begin
    sa = a_bits[WORD_W-1];
    sb = b_bits[WORD_W-1];
    ea = a_bits[WORD_W-2:FRAC_W];
    eb = b_bits[WORD_W-2:FRAC_W];
    fa = a_bits[FRAC_W-1:0];
    fb = b_bits[FRAC_W-1:0];
    // subnormal fraction is doubled so it sits at exponent one
    ma = (ea != '0) ? {1'b1, fa} : {fa, 1'b0};
    mb = (eb != '0) ? {1'b1, fb} : {fb, 1'b0};
    nan = (ea == EXP_MAX && fa != '0) || (eb == EXP_MAX && fb != '0) ||
          (ea == EXP_MAX && eb == EXP_MAX && sa != sb);

    al_next = '0;
    al_next.special = (ea == EXP_MAX) || (eb == EXP_MAX);
    if (nan) begin
      al_next.special_word = NAN_WORD;
    end else if (ea == EXP_MAX) begin
      al_next.special_word = {sa, EXP_MAX, {FRAC_W{1'b0}}};
    end else begin
      al_next.special_word = {sb, EXP_MAX, {FRAC_W{1'b0}}};
    end

    if (eb > ea) begin
      al_next.emax = eb;
      al_next.mmax = mb;
      al_next.mmin = ma;
      al_next.smax = sb;
      al_next.smin = sa;
      ediff        = eb - ea;
    end else begin
      al_next.emax = ea;
      al_next.mmax = ma;
      al_next.mmin = mb;
      al_next.smax = sa;
      al_next.smin = sb;
      ediff        = ea - eb;
    end
    al_next.gap = (ediff > EXP_W'(PAD)) ? GAP_W'(PAD) : ediff[GAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al <= al_next;
    end
  end

  logic [SUM_W-2:0] big, sml;

  always_comb begin
    big   = {al.mmax, {PAD{1'b0}}};
    sml   = {al.mmin, {PAD{1'b0}}} >> al.gap;
    sum_next              = '0;
    sum_next.special      = al.special;
    sum_next.special_word = al.special_word;
    sum_next.emax         = al.emax;
    if (al.smax == al.smin) begin
      sum_next.sum  = {1'b0, big} + {1'b0, sml};
      sum_next.sign = al.smax;
    end else if (big < sml) begin
      sum_next.sum  = {1'b0, sml - big};
      sum_next.sign = al.smin;
    end else begin
      sum_next.sum  = {1'b0, big - sml};
      sum_next.sign = al.smax;
    end
    sum_next.zero = (sum_next.sum == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_q <= sum_next;
    end
  end

endmodule

@@ hw/rtl/fpa_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_norm
// Find the leading one, then shift it to the top of the word, stopping at
// the subnormal range. Two register stages.
// ----------------------------------------------------------------------------
module fpa_norm import fpa_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sum_t  sum_d,
  output norm_t norm_q
);

  typedef struct packed {
    logic                   special;
    logic [WORD_W-1:0]      special_word;
    logic                   zero;
    logic                   sign;
    logic signed [XE_W-1:0] expo;
    logic [TOP_W-1:0]       shamt;
    logic [SUM_W-1:0]       sum;
  } lead_t;

  lead_t ld, ld_next;
  norm_t norm_next;
  logic [TOP_W-1:0] top, sh;

  always_comb begin
    top = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (sum_d.sum[i]) begin
        top = TOP_W'(i);
      end
    end
    sh = TOP_W'(SUM_W - 1) - top;
    if (EXP_W'(sh) > sum_d.emax) begin
      sh = sum_d.emax[TOP_W-1:0];
    end
    ld_next.special      = sum_d.special;
    ld_next.special_word = sum_d.special_word;
    ld_next.zero         = sum_d.zero;
    ld_next.sign         = sum_d.sign;
    ld_next.expo         = $signed({2'b00, sum_d.emax}) + $signed(XE_W'(top))
                           - $signed(XE_W'(SUM_W - 2));
    ld_next.shamt        = sh;
    ld_next.sum          = sum_d.sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld <= ld_next;
    end
  end

  always_comb begin
    norm_next.special      = ld.special;
    norm_next.special_word = ld.special_word;
    norm_next.zero         = ld.zero;
    norm_next.sign         = ld.sign;
    norm_next.expo         = ld.expo;
    norm_next.sig          = ld.sum << ld.shamt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_q <= norm_next;
    end
  end

endmodule

@@ hw/rtl/fpa_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_round
// Round to nearest even, fix up the exponent and pack the result word.
// One register stage.
// ----------------------------------------------------------------------------
module fpa_round import fpa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  norm_t             norm_d,
  output logic [WORD_W-1:0] sum_bits
);

  logic                   rnd;
  logic [MANT_W:0]        q;
  logic signed [XE_W-1:0] e;
  logic [WORD_W-1:0]      word_next;

  always_comb begin
    rnd = norm_d.sig[PAD] &
          ((|norm_d.sig[PAD-1:0]) | norm_d.sig[PAD+1]);
    q = {1'b0, norm_d.sig[SUM_W-1:PAD+1]} + (MANT_W+1)'(rnd);
    e = norm_d.expo;
    // rounding carry out of the significand
    if (q[MANT_W]) begin
      q = q >> 1;
      e = e + XE_W'(1);
    end
    if (e < 0) begin
      e = '0;
    end
    if (e == '0 && q[FRAC_W]) begin
      e = XE_W'(1);
    end

    if (norm_d.special) begin
      word_next = norm_d.special_word;
    end else if (norm_d.zero) begin
      word_next = '0;
    end else if (e >= $signed({2'b00, EXP_MAX})) begin
      word_next = {norm_d.sign, EXP_MAX, {FRAC_W{1'b0}}};
    end else begin
      word_next = {norm_d.sign, e[EXP_W-1:0], q[FRAC_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_bits <= word_next;
    end
  end

endmodule

@@ hw/rtl/single_precision_float_adder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_precision_float_adder_core
// binary32 adder, round to nearest even, five-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | data
//  ---------+---------------------------+------------------
//  input    | in_valid  / in_stall      | a_bits, b_bits
//  output   | out_valid / out_stall     | sum_bits
//
//  one word accepted per cycle while in_stall is low; each result passes
//  through the unpack, add, leading-one, shift and round stages in turn.
//  reset clears the stage valid bits only.
//  an output stall freezes the pipeline only when the output word is valid;
//  every stage shares one enable, so empty stages freeze with the rest.
// ----------------------------------------------------------------------------
module single_precision_float_adder_core import fpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] a_bits,
  input  logic [WORD_W-1:0] b_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] sum_bits
);

  localparam int STAGES = 5;

  logic              en;
  logic [STAGES-1:0] vld;
  sum_t              sum_w;
  norm_t             norm_w;

  assign en        = !(vld[STAGES-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  fpa_align u_align (
    .clk    (clk),
    .en     (en),
    .a_bits (a_bits),
    .b_bits (b_bits),
    .sum_q  (sum_w)
  );

  fpa_norm u_norm (
    .clk    (clk),
    .en     (en),
    .sum_d  (sum_w),
    .norm_q (norm_w)
  );

  fpa_round u_round (
    .clk      (clk),
    .en       (en),
    .norm_d   (norm_w),
    .sum_bits (sum_bits)
  );

endmodule

@@ tb/single_precision_float_adder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_precision_float_adder_core_tb
// Drives operand pairs into the binary32 adder with random gaps and output
// stalls, predicts each rounded sum, and checks results in order.
// ----------------------------------------------------------------------------
module single_precision_float_adder_core_tb;
  import fpa_pkg::*;

  localparam int N_RANDOM  = 1600;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 20;

  // software model of the adder; holds expected sums in arrival order
  class sum_scoreboard;
    logic [WORD_W-1:0] sums_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [WORD_W-1:0] add_words(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      logic sa, sb, smax, smin, sgn;
      logic [EXP_W-1:0] ea, eb, emax, emin;
      logic [FRAC_W:0] ma, mb, mmax, mmin;
      logic [127:0] big, sml, s;
      int gap, top, sh, expo;
      logic rnd;
      logic [63:0] q;
      logic [WORD_W-1:0] inf_w;
      sa = a[WORD_W-1]; sb = b[WORD_W-1];
      ea = a[WORD_W-2 -: EXP_W]; eb = b[WORD_W-2 -: EXP_W];
      ma = {1'b0, a[FRAC_W-1:0]}; mb = {1'b0, b[FRAC_W-1:0]};
      if (ea == EXP_MAX || eb == EXP_MAX) begin
        if ((ea == EXP_MAX && ma != 0) || (eb == EXP_MAX && mb != 0) ||
            (ea == EXP_MAX && eb == EXP_MAX && sa != sb))
          return NAN_WORD;
        inf_w = {(ea == EXP_MAX) ? sa : sb, EXP_MAX, {FRAC_W{1'b0}}};
        return inf_w;
      end
      ma = (ea != 0) ? {1'b1, a[FRAC_W-1:0]} : {a[FRAC_W-1:0], 1'b0};
      mb = (eb != 0) ? {1'b1, b[FRAC_W-1:0]} : {b[FRAC_W-1:0], 1'b0};
      if (eb > ea) begin
        emax = eb; emin = ea; mmax = mb; mmin = ma; smax = sb; smin = sa;
      end else begin
        emax = ea; emin = eb; mmax = ma; mmin = mb; smax = sa; smin = sb;
      end
      gap = int'(emax) - int'(emin);
      if (gap > PAD) gap = PAD;
      big = 128'(mmax) << PAD;
      sml = 128'(mmin) << (PAD - gap);
      if (smax == smin) begin
        s = big + sml; sgn = smax;
      end else if (big < sml) begin
        s = sml - big; sgn = smin;
      end else begin
        s = big - sml; sgn = smax;
      end
      if (s == 0) return '0;
      top = 0;
      for (int i = 0; i < 128; i++) if (s[i]) top = i;
      sh = 2 * PAD - 1 - top;
      if (sh > int'(emax)) sh = int'(emax);
      s = s << sh;
      rnd = s[PAD] && ((s & ((128'(1) << PAD) - 1)) != 0 || s[PAD+1]);
      q = 64'(s >> (PAD + 1)) + 64'(rnd);
      expo = int'(emax) + top - 2 * PAD + 2;
      if (q[FRAC_W+1]) begin
        q = q >> 1; expo++;
      end
      if (expo < 0) expo = 0;
      if (expo == 0 && q[FRAC_W]) expo = 1;
      if (expo >= int'(EXP_MAX)) return {sgn, EXP_MAX, {FRAC_W{1'b0}}};
      return {sgn, expo[EXP_W-1:0], q[FRAC_W-1:0]};
    endfunction

    function void note_operands(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      sums_q.push_back(add_words(a, b));
    endfunction

    function void check_sum(logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (sums_q.size() == 0) begin
        $error("sum_bits: unexpected word %h", got);
        errors++;
        return;
      end
      want = sums_q.pop_front();
      if (got !== want) begin
        $error("sum_bits: expected %h actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [WORD_W-1:0] a_bits, b_bits, sum_bits;
  sum_scoreboard sb;
  int idle_cnt = 0;
  bit hold_req;

  single_precision_float_adder_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .a_bits(a_bits), .b_bits(b_bits),
    .out_valid(out_valid), .out_stall(out_stall), .sum_bits(sum_bits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random operand word, biased toward exponent edges and close exponents
  function automatic logic [WORD_W-1:0] rand_word(logic [WORD_W-1:0] other);
    logic [EXP_W-1:0] e;
    logic [WORD_W-1:0] w;
    int k;
    w = $urandom();
    k = $urandom_range(0, 9);
    case (k)
      0: e = '0;
      1: e = EXP_MAX;
      2: e = EXP_W'(int'(EXP_MAX) - 1 - int'($urandom_range(0, 2)));
      3: e = EXP_W'($urandom_range(1, 3));
      4, 5: e = EXP_W'(int'(other[WORD_W-2 -: EXP_W]) + int'($urandom_range(0, 30)) - 15);
      default: e = EXP_W'($urandom());
    endcase
    w[WORD_W-2 -: EXP_W] = e;
    if ($urandom_range(0, 9) == 0) w[FRAC_W-1:0] = '0;
    if ($urandom_range(0, 9) == 0) w[FRAC_W-1:0] = {FRAC_W{1'b1}};
    return w;
  endfunction

  task automatic send_pair(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    a_bits <= a;
    b_bits <= b;
    do @(posedge clk); while (in_stall);
    sb.note_operands(a, b);
    @(negedge clk);
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
      end
      out_stall <= (gap_len() != 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_sum(sum_bits);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [WORD_W-1:0] a, b;
    logic [WORD_W-1:0] dir_a[$], dir_b[$];
    sb = new();
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    a_bits = '0;
    b_bits = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: zeros, infinities, nan, overflow, subnormals, ties, big gaps
    dir_a = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'h7F800000, 32'hFF800000,
              32'h7FC00001, 32'h3F800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001,
              32'h00400000, 32'h80000001, 32'h3F800000, 32'h3F800000, 32'h4B7FFFFF,
              32'h3F800001, 32'hFFFFFFFF, 32'h00800000, 32'h3F800000, 32'h12345678};
    dir_b = '{32'h00000000, 32'h80000000, 32'hFF800000, 32'h3F812345, 32'hBF800000,
              32'h3F800000, 32'hBF800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001,
              32'h00400000, 32'h00000001, 32'h33800000, 32'h33800001, 32'h3F000000,
              32'h33800000, 32'h00000000, 32'h807FFFFF, 32'h00000001, 32'hD2345678};
    foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) hold_req = 1'b1;
      a = $urandom();
      if ($urandom_range(0, 3) != 0) a = rand_word(a);
      b = rand_word(a);
      if ($urandom_range(0, 7) == 0) b[WORD_W-1] = ~a[WORD_W-1];
      if ($urandom_range(0, 15) == 0) b = a ^ {1'b1, {(WORD_W-1){1'b0}}};
      if ($urandom_range(0, 1)) send_pair(a, b);
      else send_pair(b, a);
    end
    in_valid <= 1'b0;
    while (sb.sums_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
